// ----- sv/fgmc_pkg.sv -----
package fgmc_pkg;

   localparam int SUCC_W = 11;
   localparam int LEN_W  = 11;

   typedef logic [SUCC_W-1:0] succ_type;
   typedef logic [LEN_W-1:0]  len_type;

   localparam len_type LEN_MAX = '1;

endpackage

// ----- sv/fgmc_if.sv -----
interface fgmc_req_if;
   logic               valid;
   logic               ready;
   fgmc_pkg::succ_type successor;
   logic               last_node;

   modport source (output valid, output successor, output last_node, input ready);
   modport sink   (input valid, input successor, input last_node, output ready);
endinterface

interface fgmc_rsp_if;
   logic              valid;
   logic              ready;
   fgmc_pkg::len_type min_cycle_len;
   logic              cycle_found;

   modport source (output valid, output min_cycle_len, output cycle_found, input ready);
   modport sink   (input valid, input min_cycle_len, input cycle_found, output ready);
endinterface

// ----- sv/fgmc_succ_mem.sv -----
module fgmc_succ_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 11
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/fgmc_walker.sv -----
module fgmc_walker #(
   parameter int MAX_NODES = 1024,
   parameter int AW        = 10,
   parameter int CW        = 11
) (
   input  logic               clock,
   input  logic               reset,
   fgmc_req_if.sink           req_bus,
   fgmc_rsp_if.source         rsp_bus,
   output logic               wr_en,
   output logic [AW-1:0]      wr_addr,
   output fgmc_pkg::succ_type wr_data,
   output logic               rd_en,
   output logic [AW-1:0]      rd_addr,
   input  fgmc_pkg::succ_type rd_data
);
   import fgmc_pkg::*;

   localparam int CMPW = (CW > SUCC_W) ? CW : SUCC_W;

   typedef enum logic [1:0] {ST_LOAD, ST_START, ST_WALK, ST_EMIT} state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   start_ff, start_in;
   logic [CW-1:0]   steps_ff, steps_in;
   logic [CW-1:0]   best_ff, best_in;
   logic            rsp_valid_ff, rsp_valid_in;
   len_type         rsp_len_ff, rsp_len_in;
   logic            rsp_found_ff, rsp_found_in;

   logic            req_take;
   logic            room;
   logic [CMPW-1:0] cur_x, count_x, start_x, best_x;
   logic            off_graph, back_home, too_long, no_better, walk_end;
   logic [CW-1:0]   start_m1;
   logic [SUCC_W-1:0] cur_m1;

   assign req_take = req_bus.valid && req_bus.ready;
   assign room     = count_ff < CW'(MAX_NODES);
   assign wr_en    = req_take && room;
   assign wr_addr  = count_ff[AW-1:0];
   assign wr_data  = req_bus.successor;

   assign cur_x   = CMPW'(rd_data);
   assign count_x = CMPW'(count_ff);
   assign start_x = CMPW'(start_ff);
   assign best_x  = CMPW'(best_ff);

   assign off_graph = (rd_data == '0) || (cur_x > count_x);
   assign back_home = cur_x == start_x;
   assign too_long  = steps_ff >= count_ff;
   // a walk already as long as the best one can no longer improve it
   assign no_better = (best_ff != '0) && (steps_ff >= best_ff);
   assign walk_end  = off_graph || back_home || too_long || no_better;

   assign start_m1 = start_ff - CW'(1);
   assign cur_m1   = rd_data - SUCC_W'(1);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      start_in     = start_ff;
      steps_in     = steps_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_len_in   = rsp_len_ff;
      rsp_found_in = rsp_found_ff;
      rd_en        = 1'b0;
      rd_addr      = start_m1[AW-1:0];
      case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               if (room) begin
                  count_in = count_ff + CW'(1);
               end
               if (req_bus.last_node) begin
                  start_in = CW'(1);
                  best_in  = '0;
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            rd_en    = 1'b1;
            rd_addr  = start_m1[AW-1:0];
            steps_in = CW'(1);
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (walk_end) begin
               if (!off_graph && back_home && !no_better) begin
                  best_in = steps_ff;
               end
               if (start_ff == count_ff) begin
                  state_in = ST_EMIT;
               end else begin
                  // read the next start node's successor right away
                  rd_en    = 1'b1;
                  rd_addr  = start_ff[AW-1:0];
                  start_in = start_ff + CW'(1);
                  steps_in = CW'(1);
               end
            end else begin
               rd_en    = 1'b1;
               rd_addr  = cur_m1[AW-1:0];
               steps_in = steps_ff + CW'(1);
            end
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_len_in   = (best_x > CMPW'(LEN_MAX)) ? LEN_MAX : best_x[LEN_W-1:0];
               rsp_found_in = best_ff != '0;
               count_in     = '0;
               best_in      = '0;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      start_ff     <= start_in;
      steps_ff     <= steps_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign req_bus.ready         = state_ff == ST_LOAD;
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.min_cycle_len = rsp_len_ff;
   assign rsp_bus.cycle_found   = rsp_found_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_NODES))
      else $error("node count above table depth");

   a_steps_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> (steps_ff <= count_ff) && (steps_ff != '0))
      else $error("walk step count out of range");

   a_best_bound: assert property (@(posedge clock) disable iff (reset)
      best_ff <= count_ff)
      else $error("best length above node count");

   a_start_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> (start_ff != '0) && (start_ff <= count_ff))
      else $error("start node out of range");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && state_in == ST_LOAD |=> count_ff == '0 && rsp_valid_ff)
      else $error("result issued without clearing the load");

endmodule

// ----- sv/functional_graph_min_cycle.sv -----
// Shortest cycle in a functional graph.
//
// req_bus carries one successor (one-based node number) per transaction; the
// transaction with last_node set closes the graph. Each node is stored by
// one memory write. Nodes past MAX_NODES are dropped, but their last_node
// mark still closes the graph.
// After the closing transaction req_bus.ready drops and the block walks the
// successor memory from every node in turn. Each walk step is one memory
// read. A setup state comes before the first walk, and an emit state posts
// the result.
// The single rsp_bus transaction holds the smallest cycle length (0 when
// none) and a found flag; it waits in an output register while the next
// graph loads, and a walk that ends while it still waits holds until it is
// taken. Reset empties the graph and drops any pending result; the
// successor memory needs no clearing since only entries loaded for the
// current graph are read.
module functional_graph_min_cycle #(
   parameter int MAX_NODES = 1024
) (
   input logic        clock,
   input logic        reset,
   fgmc_req_if.sink   req_bus,
   fgmc_rsp_if.source rsp_bus
);
   import fgmc_pkg::*;

   localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CW = $clog2(MAX_NODES + 1);

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   succ_type      wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   succ_type      rd_data;

   fgmc_succ_mem #(
      .DEPTH (MAX_NODES),
      .AW    (AW),
      .DW    (SUCC_W)
   ) u_succ_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fgmc_walker #(
      .MAX_NODES (MAX_NODES),
      .AW        (AW),
      .CW        (CW)
   ) u_walker (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// ----- tb/sv/tb_functional_graph_min_cycle.sv -----
module tb_functional_graph_min_cycle;
   timeunit 1ns;
   timeprecision 1ps;

   import fgmc_pkg::*;

   localparam int unsigned MAX_NODES = 1024;
   localparam int unsigned LONG_HOLD = 400;
   localparam int unsigned BIG_LOOP  = 100;
   localparam int unsigned SUCC_TOP  = (1 << SUCC_W) - 1;

   typedef struct packed {
      succ_type successor;
      logic     last_node;
   } node_item_type;

   typedef struct packed {
      len_type min_len;
      logic    found;
   } cycle_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fgmc_req_if req_bus ();
   fgmc_rsp_if rsp_bus ();

   functional_graph_min_cycle #(.MAX_NODES(MAX_NODES)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   node_item_type    pending_nodes[$];
   cycle_result_type expected_cycles[$];

   // graph as seen by the predictor
   succ_type    node_succ [MAX_NODES];
   int unsigned graph_size = 0;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   logic        hold_phase     = 1'b0;
   logic        rsp_hold       = 1'b0;

   int unsigned pushed_nodes   = 0;
   int unsigned accepted_nodes = 0;
   int unsigned graphs_closed  = 0;
   int unsigned results_seen   = 0;
   int unsigned found_count    = 0;
   int unsigned longest_min    = 0;
   int unsigned error_count    = 0;

   // length of the loop that returns to start, 0 if the walk escapes or repeats
   function automatic int unsigned loop_len_from(int unsigned start);
      int unsigned cur;
      int unsigned steps;
      cur   = node_succ[start - 1];
      steps = 1;
      while (1'b1) begin
         if (cur < 1 || cur > graph_size) return 0;
         if (cur == start) return steps;
         if (steps >= graph_size) return 0;
         cur = node_succ[cur - 1];
         steps++;
      end
      return 0;
   endfunction

   function automatic void accept_node(succ_type succ, logic last);
      int unsigned      best;
      int unsigned      len;
      cycle_result_type res;
      if (graph_size < MAX_NODES) begin
         node_succ[graph_size] = succ;
         graph_size++;
      end
      if (last) begin
         best = 0;
         for (int unsigned node = 1; node <= graph_size; node++) begin
            len = loop_len_from(node);
            if (len != 0 && (best == 0 || len < best)) best = len;
         end
         res.min_len = (best > LEN_MAX) ? LEN_MAX : len_type'(best);
         res.found   = (best != 0);
         expected_cycles.push_back(res);
         graphs_closed++;
         graph_size = 0;
      end
   endfunction

   function automatic void queue_node(int unsigned succ, logic last);
      node_item_type item;
      item.successor = succ_type'(succ);
      item.last_node = last;
      pending_nodes.push_back(item);
      pushed_nodes++;
   endfunction

   // in-range successors, but about bad_pct percent of them point outside the graph
   function automatic int unsigned queue_random_graph(int unsigned n, int unsigned bad_pct);
      int unsigned succ;
      for (int unsigned k = 1; k <= n; k++) begin
         if ($urandom_range(99) < bad_pct) begin
            case ($urandom_range(3))
               0: succ = 0;
               1: succ = SUCC_TOP;
               2: succ = MAX_NODES;
               default: succ = $urandom_range(SUCC_TOP, n + 1);
            endcase
         end else begin
            succ = $urandom_range(n, 1);
         end
         queue_node(succ, k == n);
      end
      return n;
   endfunction

   always @(posedge clock) begin : feed_nodes
      node_item_type item;
      if (reset) begin
         req_bus.valid     <= 1'b0;
         req_bus.successor <= '0;
         req_bus.last_node <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            accept_node(req_bus.successor, req_bus.last_node);
            accepted_nodes++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_nodes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               item = pending_nodes.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.successor <= item.successor;
               req_bus.last_node <= item.last_node;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_cycles
      cycle_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (expected_cycles.size() == 0) begin
               $error("unexpected transaction: min_cycle_len %0d, cycle_found %0b",
                      rsp_bus.min_cycle_len, rsp_bus.cycle_found);
               error_count++;
            end else begin
               want = expected_cycles.pop_front();
               if (rsp_bus.min_cycle_len !== want.min_len) begin
                  $error("min_cycle_len: expected %0d, actual %0d",
                         want.min_len, rsp_bus.min_cycle_len);
                  error_count++;
               end
               if (rsp_bus.cycle_found !== want.found) begin
                  $error("cycle_found: expected %0b, actual %0b",
                         want.found, rsp_bus.cycle_found);
                  error_count++;
               end
               if (want.found) begin
                  found_count++;
                  if (want.min_len > longest_min) longest_min = want.min_len;
               end
            end
         end
         rsp_bus.ready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // hold the result channel off while the sender keeps loading graphs
   initial begin : long_hold
      wait (hold_phase);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin : watchdog
      #16_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic wait_drained();
      while (accepted_nodes != pushed_nodes || expected_cycles.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_phase(int unsigned send_pct, int unsigned recv_pct,
                            int unsigned quota);
      int unsigned queued;
      int unsigned n;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      queued = 0;
      while (queued < quota) begin
         n = ($urandom_range(11) == 0) ? $urandom_range(60, 11) : $urandom_range(10, 1);
         queued += queue_random_graph(n, ($urandom_range(3) == 0) ? 50 : 8);
      end
      wait_drained();
   endtask

   initial begin : run
      req_bus.valid     = 1'b0;
      req_bus.successor = '0;
      req_bus.last_node = 1'b0;
      rsp_bus.ready     = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // single node: self loop, successor zero, successor all ones
      queue_node(1, 1'b1);
      queue_node(0, 1'b1);
      queue_node(SUCC_TOP, 1'b1);
      // two-node loop
      queue_node(2, 1'b0);
      queue_node(1, 1'b1);
      // chain that escapes past the node count
      queue_node(2, 1'b0);
      queue_node(3, 1'b0);
      queue_node(4, 1'b1);
      // tail leading into a loop of two
      queue_node(2, 1'b0);
      queue_node(3, 1'b0);
      queue_node(4, 1'b0);
      queue_node(3, 1'b1);
      // loop of three beside a self loop and a tail
      queue_node(2, 1'b0);
      queue_node(3, 1'b0);
      queue_node(1, 1'b0);
      queue_node(4, 1'b0);
      queue_node(4, 1'b1);
      // successor at the top of the node range in a small graph
      queue_node(MAX_NODES, 1'b0);
      queue_node(1, 1'b1);
      // every node points to the first: no node but the first returns
      queue_node(1, 1'b0);
      queue_node(1, 1'b0);
      queue_node(1, 1'b1);
      wait_drained();

      // one long loop
      for (int unsigned k = 1; k <= BIG_LOOP; k++)
         queue_node((k % BIG_LOOP) + 1, k == BIG_LOOP);
      wait_drained();

      run_phase(0, 0, 120);
      run_phase(82, 0, 100);
      run_phase(0, 82, 100);
      run_phase(28, 28, 100);
      hold_phase = 1'b1;
      run_phase(0, 0, 100);

      repeat (64) @(posedge clock);

      $display("graphs checked: %0d of %0d closed, %0d nodes accepted",
               results_seen, graphs_closed, accepted_nodes);
      $display("graphs with a cycle: %0d, largest shortest cycle: %0d",
               found_count, longest_min);
      if (error_count == 0 && expected_cycles.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/fgmc_pkg.sv
sv/fgmc_if.sv
sv/fgmc_succ_mem.sv
sv/fgmc_walker.sv
sv/functional_graph_min_cycle.sv
tb/sv/tb_functional_graph_min_cycle.sv
